[hw/rtl/lwf_pkg.sv]
// Shared types and constants of the lookahead waypoint follower.
package lwf_pkg;

    // Table size and the widths that follow from it.
    localparam int MAX_WAYPOINTS = 64;
    localparam int ADDR_W        = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int LEN_W         = $clog2(MAX_WAYPOINTS + 1);

    // Fixed field widths of the channels.
    localparam int OP_W     = 2;
    localparam int SLOT_W   = 6;
    localparam int PLEN_W   = 7;
    localparam int COORD_W  = 32;
    localparam int HEAD_W   = 16;
    localparam int TIDX_W   = 7;
    localparam int RADIUS_W = 31;
    localparam int SQ_W     = 2 * RADIUS_W;

    // Reset value of the lookahead radius, 1.0 in unsigned Q15.16.
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(65536);

    // Command codes.
    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_COMMIT = 2'd1,
        OP_POSE   = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    // One pose or waypoint: position and heading.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [HEAD_W-1:0]  h;
    } pose_t;

    localparam int POSE_W = $bits(pose_t);

endpackage

[hw/rtl/lwf_if.sv]
// Valid/ready channel interfaces for commands and results.
interface lwf_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [lwf_pkg::OP_W-1:0]             op;
    logic [lwf_pkg::SLOT_W-1:0]           waypoint_slot;
    logic [lwf_pkg::PLEN_W-1:0]           path_length;
    logic signed [lwf_pkg::COORD_W-1:0]   pos_x;
    logic signed [lwf_pkg::COORD_W-1:0]   pos_y;
    logic signed [lwf_pkg::HEAD_W-1:0]    heading;

    modport source (output valid, op, waypoint_slot, path_length, pos_x, pos_y, heading,
                    input ready);
    modport sink   (input valid, op, waypoint_slot, path_length, pos_x, pos_y, heading,
                    output ready);
endinterface

interface lwf_res_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [lwf_pkg::COORD_W-1:0]   target_x;
    logic signed [lwf_pkg::COORD_W-1:0]   target_y;
    logic signed [lwf_pkg::HEAD_W-1:0]    target_heading;
    logic                                 finished;
    logic [lwf_pkg::TIDX_W-1:0]           target_index;

    modport source (output valid, target_x, target_y, target_heading, finished, target_index,
                    input ready);
    modport sink   (input valid, target_x, target_y, target_heading, finished, target_index,
                    output ready);
endinterface

[hw/rtl/lwf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module lwf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/lwf_dist.sv]
// Two-stage squared-distance compare of two points against the squared radius.
module lwf_dist (
    input  logic                           clk,
    input  lwf_pkg::pose_t                 a,
    input  lwf_pkg::pose_t                 b,
    input  logic [lwf_pkg::SQ_W-1:0]       radius_sq,
    output logic                           lt,
    output logic                           le
);

    logic signed [lwf_pkg::COORD_W:0]   dx;
    logic signed [lwf_pkg::COORD_W:0]   dy;
    logic [lwf_pkg::COORD_W:0]          abs_x;
    logic [lwf_pkg::COORD_W:0]          abs_y;
    logic [lwf_pkg::RADIUS_W-1:0]       ax_reg;
    logic [lwf_pkg::RADIUS_W-1:0]       ay_reg;
    logic                               far_reg;
    logic [lwf_pkg::SQ_W-1:0]           sqx_reg;
    logic [lwf_pkg::SQ_W-1:0]           sqy_reg;
    logic                               far2_reg;
    logic [lwf_pkg::SQ_W:0]             d2;

    // Exact differences and their magnitudes.
    always_comb
    begin
        dx    = $signed({a.x[lwf_pkg::COORD_W-1], a.x}) - $signed({b.x[lwf_pkg::COORD_W-1], b.x});
        dy    = $signed({a.y[lwf_pkg::COORD_W-1], a.y}) - $signed({b.y[lwf_pkg::COORD_W-1], b.y});
        abs_x = dx[lwf_pkg::COORD_W] ? unsigned'(-dx) : unsigned'(dx);
        abs_y = dy[lwf_pkg::COORD_W] ? unsigned'(-dy) : unsigned'(dy);
    end

    // Stage one: magnitudes, and a flag for points beyond any radius.
    always_ff @(posedge clk)
    begin
        ax_reg  <= abs_x[lwf_pkg::RADIUS_W-1:0];
        ay_reg  <= abs_y[lwf_pkg::RADIUS_W-1:0];
        far_reg <= (abs_x[lwf_pkg::COORD_W:lwf_pkg::RADIUS_W] != '0) ||
                   (abs_y[lwf_pkg::COORD_W:lwf_pkg::RADIUS_W] != '0);
    end

    // Stage two: the two squares.
    always_ff @(posedge clk)
    begin
        sqx_reg  <= lwf_pkg::SQ_W'(ax_reg) * lwf_pkg::SQ_W'(ax_reg);
        sqy_reg  <= lwf_pkg::SQ_W'(ay_reg) * lwf_pkg::SQ_W'(ay_reg);
        far2_reg <= far_reg;
    end

    // Sum and compare against the squared radius.
    always_comb
    begin
        d2 = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        lt = !far2_reg && (d2 <  {1'b0, radius_sq});
        le = !far2_reg && (d2 <= {1'b0, radius_sq});
    end

endmodule

[hw/rtl/lookahead_waypoint_follower.sv]
// Top level of the lookahead waypoint follower: table memory, sequencer and result register.
//
//   channel   dir   handshake          payload
//   cmd       in    valid/ready        op, waypoint_slot, path_length, pos_x, pos_y, heading
//   res       out   valid/ready        target_x, target_y, target_heading, finished, target_index
//   cfg       in    cfg_we, no wait    cfg_wdata (lookahead_distance)
//
// Waypoint writes and path commits complete in S_IDLE. A pose update on an empty path goes
// straight to S_OUT; otherwise the last waypoint is checked against the previous pose, and
// if the path is not finished the walk stops on a waypoint or runs off the end of the path.
// Each waypoint visited costs one table read plus the two-stage distance compare.
// Reset clears the path length, the index and the previous pose and sets the radius to 1.0;
// the table is not cleared. A result waiting in the output register holds back the next one.
module lookahead_waypoint_follower (
    input  logic                              clk,
    input  logic                              rst_n,
    lwf_cmd_if.sink                           cmd,
    lwf_res_if.source                         res,
    input  logic                              cfg_we,
    input  logic [lwf_pkg::RADIUS_W-1:0]      cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LAST_RD,
        S_LAST_C1,
        S_LAST_C2,
        S_WALK_RD,
        S_WALK_C1,
        S_WALK_C2,
        S_TGT_RD,
        S_OUT
    } state_t;

    state_t                               state_reg;
    logic [lwf_pkg::RADIUS_W-1:0]         radius_reg;
    logic [lwf_pkg::SQ_W-1:0]             radius_sq_reg;
    logic [lwf_pkg::LEN_W-1:0]            length_reg;
    logic [lwf_pkg::LEN_W-1:0]            index_reg;
    lwf_pkg::pose_t                       prev_reg;
    lwf_pkg::pose_t                       cur_reg;
    lwf_pkg::pose_t                       target_reg;
    logic                                 fin_reg;
    logic                                 out_valid_reg;
    lwf_pkg::pose_t                       out_pose_reg;
    logic                                 out_fin_reg;
    logic [lwf_pkg::LEN_W-1:0]            out_index_reg;

    lwf_pkg::pose_t                       cmd_pose;
    logic                                 cmd_xfer;
    logic                                 wr_en;
    logic [lwf_pkg::ADDR_W-1:0]           wr_addr;
    logic                                 rd_en;
    logic [lwf_pkg::ADDR_W-1:0]           rd_addr;
    logic [lwf_pkg::POSE_W-1:0]           rd_data;
    lwf_pkg::pose_t                       wp;
    lwf_pkg::pose_t                       dist_a;
    logic                                 dist_lt;
    logic                                 dist_le;
    logic [lwf_pkg::ADDR_W-1:0]           last_addr;
    logic [lwf_pkg::LEN_W-1:0]            index_inc;
    logic [lwf_pkg::LEN_W-1:0]            commit_len;

    // Command decode.
    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign cmd_pose  = '{x: cmd.pos_x, y: cmd.pos_y, h: cmd.heading};
    assign wr_en     = cmd_xfer && (lwf_pkg::op_t'(cmd.op) == lwf_pkg::OP_WRITE) &&
                       (32'(cmd.waypoint_slot) < lwf_pkg::MAX_WAYPOINTS);
    assign wr_addr   = lwf_pkg::ADDR_W'(cmd.waypoint_slot);
    assign commit_len = (32'(cmd.path_length) > lwf_pkg::MAX_WAYPOINTS) ?
                        lwf_pkg::LEN_W'(lwf_pkg::MAX_WAYPOINTS) :
                        lwf_pkg::LEN_W'(cmd.path_length);

    assign last_addr = lwf_pkg::ADDR_W'(length_reg - 1'b1);
    assign index_inc = index_reg + 1'b1;
    assign wp        = rd_data;

    // Waypoint table.
    lwf_ram #(
        .WIDTH (lwf_pkg::POSE_W),
        .DEPTH (lwf_pkg::MAX_WAYPOINTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd_pose),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The finish check measures from the previous pose, the walk from the current one.
    assign dist_a = (state_reg == S_LAST_RD) ? prev_reg : cur_reg;

    lwf_dist u_dist (
        .clk       (clk),
        .a         (dist_a),
        .b         (wp),
        .radius_sq (radius_sq_reg),
        .lt        (dist_lt),
        .le        (dist_le)
    );

    // Table read requests issued by the sequencer.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = last_addr;
        case (state_reg)
            S_IDLE:
            begin
                rd_en   = cmd_xfer && (lwf_pkg::op_t'(cmd.op) == lwf_pkg::OP_POSE) &&
                          (length_reg != '0);
                rd_addr = last_addr;
            end
            S_LAST_C2:
            begin
                rd_en   = !dist_le;
                rd_addr = (index_reg < length_reg) ? lwf_pkg::ADDR_W'(index_reg) : last_addr;
            end
            S_WALK_C2:
            begin
                rd_en   = dist_lt;
                rd_addr = (index_inc < length_reg) ? lwf_pkg::ADDR_W'(index_inc) : last_addr;
            end
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = last_addr;
            end
        endcase
    end

    // Lookahead radius and its square.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= lwf_pkg::RADIUS_RESET;
            radius_sq_reg <= lwf_pkg::SQ_W'(lwf_pkg::RADIUS_RESET) *
                             lwf_pkg::SQ_W'(lwf_pkg::RADIUS_RESET);
        end
        else
        begin
            if (cfg_we)
            begin
                radius_reg <= cfg_wdata;
            end
            radius_sq_reg <= lwf_pkg::SQ_W'(radius_reg) * lwf_pkg::SQ_W'(radius_reg);
        end
    end

    // Sequencer, path state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            length_reg    <= '0;
            index_reg     <= '0;
            prev_reg      <= '0;
            cur_reg       <= '0;
            target_reg    <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_pose_reg  <= '0;
            out_fin_reg   <= 1'b0;
            out_index_reg <= '0;
        end
        else
        begin
            // The consumer takes the waiting result; in S_OUT a new result takes its place.
            if (res.ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_xfer)
                    begin
                        case (lwf_pkg::op_t'(cmd.op))
                            lwf_pkg::OP_COMMIT:
                            begin
                                length_reg <= commit_len;
                                index_reg  <= '0;
                            end
                            lwf_pkg::OP_POSE:
                            begin
                                cur_reg    <= cmd_pose;
                                target_reg <= cmd_pose;
                                fin_reg    <= 1'b1;
                                state_reg  <= (length_reg == '0) ? S_OUT : S_LAST_RD;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_LAST_RD:
                begin
                    state_reg <= S_LAST_C1;
                end
                S_LAST_C1:
                begin
                    state_reg <= S_LAST_C2;
                end
                S_LAST_C2:
                begin
                    if (dist_le)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        fin_reg   <= 1'b0;
                        state_reg <= (index_reg < length_reg) ? S_WALK_RD : S_TGT_RD;
                    end
                end
                S_WALK_RD:
                begin
                    target_reg <= wp;
                    state_reg  <= S_WALK_C1;
                end
                S_WALK_C1:
                begin
                    state_reg <= S_WALK_C2;
                end
                S_WALK_C2:
                begin
                    if (dist_lt)
                    begin
                        index_reg <= index_inc;
                        state_reg <= (index_inc < length_reg) ? S_WALK_RD : S_TGT_RD;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_TGT_RD:
                begin
                    target_reg <= wp;
                    state_reg  <= S_OUT;
                end
                S_OUT:
                begin
                    // Load the result once the output register is free.
                    if (!out_valid_reg || res.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_pose_reg  <= target_reg;
                        out_fin_reg   <= fin_reg;
                        out_index_reg <= index_reg;
                        prev_reg      <= cur_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result channel.
    assign res.valid          = out_valid_reg;
    assign res.target_x       = out_pose_reg.x;
    assign res.target_y       = out_pose_reg.y;
    assign res.target_heading = out_pose_reg.h;
    assign res.finished       = out_fin_reg;
    assign res.target_index   = lwf_pkg::TIDX_W'(out_index_reg);

endmodule

[tb/lwf_target_checker.sv]
// Checker for the lookahead waypoint follower: tracks the path state and scores every result.
`timescale 1ns / 100ps

module lwf_target_checker
    import lwf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    lwf_cmd_if                  cmd,
    lwf_res_if                  res,
    input  logic                cfg_we,
    input  logic [RADIUS_W-1:0] cfg_wdata,
    output int                  pending,
    output int                  fail_count
);

    // One expected target as it should appear on the result channel.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [HEAD_W-1:0]  h;
        logic                      fin;
        logic [TIDX_W-1:0]         idx;
    } target_t;

    // Shadow copy of the follower state.
    pose_t               wp_table [MAX_WAYPOINTS];
    logic [LEN_W-1:0]    path_len;
    logic [LEN_W-1:0]    walk_index;
    pose_t               last_pose;
    logic [RADIUS_W-1:0] radius;
    target_t             target_q[$];

    // Orders the distance between two points against the radius:
    // -1 strictly inside, 0 exactly on it, 1 outside.
    function automatic int radius_order(input pose_t a, input pose_t b);
        longint      dx;
        longint      dy;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] d2;
        logic [63:0] r2;
        dx = longint'($signed(a.x)) - longint'($signed(b.x));
        dy = longint'($signed(a.y)) - longint'($signed(b.y));
        ax = (dx < 0) ? 64'(-dx) : 64'(dx);
        ay = (dy < 0) ? 64'(-dy) : 64'(dy);
        // A difference this large lies beyond any radius the register can hold.
        if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000)
            return 1;
        d2 = ax * ax + ay * ay;
        r2 = 64'(radius) * 64'(radius);
        if (d2 < r2)
            return -1;
        return (d2 == r2) ? 0 : 1;
    endfunction

    // Works out the target for one pose update and advances the shadow state.
    function automatic target_t follow_pose(input pose_t now_pose);
        target_t t;
        pose_t   tgt;
        logic    fin;
        fin = 1'b0;
        if (path_len == 0) begin
            tgt = now_pose;
            fin = 1'b1;
        end
        else if (radius_order(last_pose, wp_table[path_len - 1]) <= 0) begin
            // The previous pose reached the last waypoint: the path is done.
            tgt = now_pose;
            fin = 1'b1;
        end
        else begin
            // Skip every waypoint strictly inside the lookahead circle.
            while (walk_index < path_len &&
                   radius_order(now_pose, wp_table[walk_index]) < 0)
                walk_index++;
            tgt = (walk_index < path_len) ? wp_table[walk_index] : wp_table[path_len - 1];
        end
        last_pose = now_pose;
        t.x   = tgt.x;
        t.y   = tgt.y;
        t.h   = tgt.h;
        t.fin = fin;
        t.idx = TIDX_W'(walk_index);
        return t;
    endfunction

    task automatic compare_field(input string name, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Follow every transfer on both channels and the register writes.
    always @(posedge clk or negedge rst_n) begin : watch
        target_t want;
        pose_t   cur;
        if (!rst_n) begin
            path_len   = '0;
            walk_index = '0;
            last_pose  = '0;
            radius     = RADIUS_RESET;
            target_q.delete();
            pending   <= 0;
        end
        else begin
            if (cfg_we)
                radius = cfg_wdata;

            // Score a result transfer against the oldest expected target.
            if (res.valid && res.ready) begin
                if (target_q.size() == 0) begin
                    $error("result transfer with nothing expected: target_x %0d",
                           res.target_x);
                    fail_count++;
                end
                else begin
                    want = target_q.pop_front();
                    compare_field("target_x", want.x, res.target_x);
                    compare_field("target_y", want.y, res.target_y);
                    compare_field("target_heading", want.h, res.target_heading);
                    compare_field("finished", want.fin, res.finished);
                    compare_field("target_index", want.idx, res.target_index);
                end
            end

            // Apply a command transfer to the shadow state.
            if (cmd.valid && cmd.ready) begin
                cur = {cmd.pos_x, cmd.pos_y, cmd.heading};
                case (cmd.op)
                    OP_WRITE: begin
                        if (cmd.waypoint_slot < MAX_WAYPOINTS)
                            wp_table[cmd.waypoint_slot] = cur;
                    end
                    OP_COMMIT: begin
                        path_len   = (cmd.path_length > MAX_WAYPOINTS) ?
                                     LEN_W'(MAX_WAYPOINTS) : LEN_W'(cmd.path_length);
                        walk_index = '0;
                    end
                    OP_POSE: target_q.push_back(follow_pose(cur));
                    default: ;
                endcase
            end
            pending <= target_q.size();
        end
    end

endmodule

[tb/lookahead_waypoint_follower_tb.sv]
// Testbench top for the lookahead waypoint follower: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module lookahead_waypoint_follower_tb;
    import lwf_pkg::*;

    localparam int     ITEM_TARGET   = 700;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     DRAIN_CYCLES  = 250;
    localparam int     CYCLE_LIMIT   = 1_000_000;
    localparam longint RADIUS_MAX    = 64'h7FFF_FFFF;

    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
    localparam logic [COORD_W-1:0] ONE_METRE = 32'h0001_0000;
    localparam logic [HEAD_W-1:0]  HEAD_MAX  = 16'h7FFF;
    localparam logic [HEAD_W-1:0]  HEAD_MIN  = 16'h8000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [RADIUS_W-1:0] cfg_wdata;

    lwf_cmd_if cmd_ch ();
    lwf_res_if res_ch ();

    int          pending;
    int          fail_count;
    int          item_count;
    int          hold_requests = 0;
    bit          quiet = 1'b0;
    longint      cur_radius;
    int unsigned cycle_count;

    // Stimulus-side copy of the waypoint geometry, used to aim poses.
    logic [COORD_W-1:0] way_x [MAX_WAYPOINTS];
    logic [COORD_W-1:0] way_y [MAX_WAYPOINTS];
    bit                 way_known [MAX_WAYPOINTS];

    lookahead_waypoint_follower dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    lwf_target_checker target_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .res        (res_ch),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Give up if the run hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : result_sink
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (hold_requests != holds_done) begin
                holds_done++;
                hold_left = HOLD_CYCLES - 1;
                res_ch.ready <= 1'b0;
            end
            else begin
                res_ch.ready <= quiet || ($urandom_range(0, 99) >= 14);
            end
        end
    end

    // Uniform offset in [-span, span]; span is clipped to the radius range.
    function automatic longint jitter(input longint span);
        longint s;
        if (span <= 0)
            return 0;
        s = (span > RADIUS_MAX) ? RADIUS_MAX : span;
        return longint'($urandom_range(0, 32'(2 * s))) - s;
    endfunction

    function automatic logic [COORD_W-1:0] near(input logic [COORD_W-1:0] c,
                                                input longint span);
        return COORD_W'(longint'($signed(c)) + jitter(span));
    endfunction

    // Number of table entries written without a hole from slot zero.
    function automatic int written_prefix();
        int n;
        n = 0;
        while (n < MAX_WAYPOINTS && way_known[n])
            n++;
        return n;
    endfunction

    function automatic longint pick_radius();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return 1;
            2:       return RADIUS_MAX;
            3:       return longint'($urandom) & RADIUS_MAX;
            default: return longint'($urandom_range(1 << 12, 1 << 22));
        endcase
    endfunction

    // Offers one command and returns at the edge of its transfer.
    task automatic send_item(input op_t op, input logic [SLOT_W-1:0] slot,
                             input logic [PLEN_W-1:0] plen, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [HEAD_W-1:0] h);
        int gap;
        gap = 0;
        while (!quiet && $urandom_range(0, 99) < 14)
            gap++;
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.op            <= op;
        cmd_ch.waypoint_slot <= slot;
        cmd_ch.path_length   <= plen;
        cmd_ch.pos_x         <= x;
        cmd_ch.pos_y         <= y;
        cmd_ch.heading       <= h;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (op != OP_UNUSED)
            item_count++;
    endtask

    task automatic write_waypoint(input int slot, input logic [COORD_W-1:0] x,
                                  input logic [COORD_W-1:0] y, input logic [HEAD_W-1:0] h);
        way_x[slot]     = x;
        way_y[slot]     = y;
        way_known[slot] = 1'b1;
        send_item(OP_WRITE, SLOT_W'(slot), PLEN_W'($urandom), x, y, h);
    endtask

    task automatic commit_path(input int len);
        send_item(OP_COMMIT, SLOT_W'($urandom), PLEN_W'(len), COORD_W'($urandom),
                  COORD_W'($urandom), HEAD_W'($urandom));
    endtask

    task automatic send_pose(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [HEAD_W-1:0] h);
        send_item(OP_POSE, SLOT_W'($urandom), PLEN_W'($urandom), x, y, h);
    endtask

    // Lets the block go idle, then waits out any command still in flight.
    task automatic wait_idle(input int extra);
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_radius(input longint r);
        wait_idle(SETTLE_CYCLES);
        cfg_we    <= 1'b1;
        cfg_wdata <= RADIUS_W'(r);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_radius = r;
    endtask

    // One random command of any kind; commits never reach unwritten slots.
    task automatic noise_item();
        int lim;
        lim = written_prefix();
        case ($urandom_range(0, 3))
            0: write_waypoint($urandom_range(0, MAX_WAYPOINTS - 1), COORD_W'($urandom),
                              COORD_W'($urandom), HEAD_W'($urandom));
            1: commit_path((lim == MAX_WAYPOINTS) ? $urandom_range(0, 127)
                                                  : $urandom_range(0, lim));
            2: send_pose(COORD_W'($urandom), COORD_W'($urandom), HEAD_W'($urandom));
            default: send_item(OP_UNUSED, SLOT_W'($urandom), PLEN_W'($urandom),
                               COORD_W'($urandom), COORD_W'($urandom), HEAD_W'($urandom));
        endcase
    endtask

    // Loads a path, commits it and drives poses along it to the finish.
    task automatic run_path_phase();
        int     k;
        int     len;
        int     j;
        longint drift_x;
        longint drift_y;
        longint px;
        longint py;
        logic [HEAD_W-1:0] h;
        k = $urandom_range(0, 99);
        if (k < 4)
            len = 0;
        else if (k < 14)
            len = $urandom_range(33, MAX_WAYPOINTS);
        else
            len = $urandom_range(1, 8);
        drift_x = jitter(cur_radius / 2);
        drift_y = jitter(cur_radius / 2);
        px = jitter(1 << 28);
        py = jitter(1 << 28);
        for (int i = 0; i < len; i++) begin
            if (i > 0) begin
                px += drift_x + jitter(cur_radius);
                py += drift_y + jitter(cur_radius);
            end
            write_waypoint(i, COORD_W'(px), COORD_W'(py), HEAD_W'($urandom));
            if ($urandom_range(0, 99) < 5)
                noise_item();
        end
        // A full table may also be committed with an oversized length.
        if (len == MAX_WAYPOINTS && $urandom_range(0, 3) == 0)
            commit_path($urandom_range(MAX_WAYPOINTS + 1, 127));
        else
            commit_path(len);
        j = 0;
        repeat ((len == 0) ? 3 : len + 4) begin
            h = HEAD_W'($urandom);
            if (len == 0) begin
                send_pose(COORD_W'($urandom), COORD_W'($urandom), h);
            end
            else begin
                case ($urandom_range(0, 9))
                    0:       send_pose(way_x[j], way_y[j], h);
                    1:       send_pose(COORD_W'(longint'($signed(way_x[j])) + cur_radius),
                                       way_y[j], h);
                    default: send_pose(near(way_x[j], cur_radius),
                                       near(way_y[j], cur_radius), h);
                endcase
                j += $urandom_range(0, 2);
                if (j > len - 1)
                    j = len - 1;
            end
            if ($urandom_range(0, 99) < 3)
                noise_item();
        end
    endtask

    // Poses against a stale table, with or without a fresh commit.
    task automatic run_broken_phase();
        int lim;
        int s;
        lim = written_prefix();
        if ($urandom_range(0, 1) == 1)
            commit_path((lim == MAX_WAYPOINTS) ? $urandom_range(0, 127)
                                               : $urandom_range(0, lim));
        repeat ($urandom_range(1, 6)) begin
            if (lim > 0) begin
                s = $urandom_range(0, lim - 1);
                send_pose(near(way_x[s], cur_radius), near(way_y[s], cur_radius),
                          HEAD_W'($urandom));
            end
            else begin
                send_pose(COORD_W'($urandom), COORD_W'($urandom), HEAD_W'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        int k;
        bit pressure_done;
        pressure_done = 1'b0;
        item_count    = 0;
        cur_radius    = longint'(RADIUS_RESET);
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        cmd_ch.valid         <= 1'b0;
        cmd_ch.op            <= OP_WRITE;
        cmd_ch.waypoint_slot <= '0;
        cmd_ch.path_length   <= '0;
        cmd_ch.pos_x         <= '0;
        cmd_ch.pos_y         <= '0;
        cmd_ch.heading       <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty path after reset, extreme pose and heading, then an unused op code.
        send_pose(COORD_MIN, COORD_MAX, HEAD_MIN);
        send_item(OP_UNUSED, SLOT_W'($urandom), PLEN_W'($urandom), COORD_W'($urandom),
                  COORD_W'($urandom), HEAD_W'($urandom));

        // Four waypoints: one exactly on the radius, the last at the far corner.
        write_waypoint(0, '0, '0, HEAD_MAX);
        write_waypoint(1, ONE_METRE, '0, HEAD_W'($urandom));
        write_waypoint(2, 3 * ONE_METRE, '0, HEAD_W'($urandom));
        write_waypoint(3, COORD_MAX, COORD_MIN, HEAD_W'($urandom));
        commit_path(4);
        send_pose('0, '0, HEAD_W'($urandom));
        send_pose(ONE_METRE, 32'd1, HEAD_W'($urandom));
        send_pose(COORD_MAX, COORD_MIN, HEAD_W'($urandom));
        send_pose('0, '0, HEAD_W'($urandom));

        // Widest radius: finish twice, then a walk that runs off the end.
        set_radius(RADIUS_MAX);
        commit_path(3);
        send_pose('0, '0, HEAD_W'($urandom));
        send_pose(COORD_MIN, COORD_MIN, HEAD_W'($urandom));
        send_pose('0, '0, HEAD_W'($urandom));

        // Zero radius: only an exact hit counts, and it never advances the index.
        set_radius(0);
        commit_path(4);
        send_pose('0, '0, HEAD_W'($urandom));
        send_pose(COORD_MAX, COORD_MIN, HEAD_W'($urandom));
        send_pose(32'd5, 32'd5, HEAD_W'($urandom));

        // Random phases until enough commands have been sent.
        while (item_count < ITEM_TARGET) begin
            quiet <= (item_count >= 150 && item_count < 260);
            if ($urandom_range(0, 3) == 0)
                set_radius(pick_radius());
            if (!pressure_done && item_count >= 350) begin
                // Keep offering poses while the result side holds off.
                pressure_done = 1'b1;
                hold_requests <= hold_requests + 1;
                repeat (12) run_broken_phase();
            end
            k = $urandom_range(0, 99);
            if (k < 70)
                run_path_phase();
            else if (k < 85)
                repeat ($urandom_range(3, 10)) noise_item();
            else
                run_broken_phase();
        end

        wait_idle(DRAIN_CYCLES);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
